### hdl/srra_pkg.sv
// Shared types and constants for the stream receive reassembly unit.
// Holds field widths, status and request codes, and the controller/datapath interface.
// No dependencies.
package srra_pkg;

  localparam int OFS_W     = 62;
  localparam int LEN_W     = 21;
  localparam int ST_W      = 3;
  localparam int REQ_W     = 2;
  localparam int ID_W      = 2;
  localparam int GAP_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 21;

  localparam logic [OFS_W-1:0] OFS_ALL_ONES  = '1;
  localparam logic [LEN_W-1:0] BUF_LIMIT_RST = 21'd65536;
  localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_PARAM = 3'd1,
    ST_STATE = 3'd2,
    ST_PROTO = 3'd3,
    ST_NORES = 3'd4,
    ST_SMALL = 3'd5,
    ST_RESET = 3'd6
  } status_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME   = 2'd0,
    REQ_CONSUME = 2'd1,
    REQ_RESET   = 2'd2,
    REQ_LIMIT   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PASS_MERGE   = 3'd0,
    PASS_COMPACT = 3'd1,
    PASS_FIND    = 3'd2,
    PASS_SHIFT   = 3'd3,
    PASS_READY   = 3'd4
  } pass_t;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_F_END    = 4'd2,
    OP_F_CHK    = 4'd3,
    OP_F_TRIM   = 4'd4,
    OP_F_EVAL1  = 4'd5,
    OP_F_EVAL2  = 4'd6,
    OP_F_APPEND = 4'd7,
    OP_C_START  = 4'd8,
    OP_C_EVAL   = 4'd9,
    OP_C_APPLY  = 4'd10,
    OP_C_SHRINK = 4'd11,
    OP_R_APPLY  = 4'd12,
    OP_L_APPLY  = 4'd13,
    OP_EMIT     = 4'd14
  } op_t;

  typedef struct packed {
    logic pass_busy;
    logic frame_scan;
    logic frame_fit;
    logic found;
    logic n_zero;
    logic emptied;
    logic out_stall;
  } stat_t;

endpackage

### hdl/srra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module srra_ram #(
  parameter int WIDTH = 83,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/srra_ctrl.sv
// Sequencer for the reassembly unit: steps each request through its datapath operations.
// Depends on srra_pkg.
module srra_ctrl
  import srra_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] req_type,
  input  stat_t            stat,
  output op_t              op
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_F_END     = 19'h00002,
    S_F_CHK     = 19'h00004,
    S_F_TRIM    = 19'h00008,
    S_F_SCAN    = 19'h00010,
    S_F_EVAL1   = 19'h00020,
    S_F_EVAL2   = 19'h00040,
    S_F_COMPACT = 19'h00080,
    S_F_APPEND  = 19'h00100,
    S_C_START   = 19'h00200,
    S_C_FIND    = 19'h00400,
    S_C_EVAL    = 19'h00800,
    S_C_APPLY   = 19'h01000,
    S_C_SHIFT   = 19'h02000,
    S_C_SHRINK  = 19'h04000,
    S_C_READY   = 19'h08000,
    S_R_APPLY   = 19'h10000,
    S_L_APPLY   = 19'h20000,
    S_EMIT      = 19'h40000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_ACCEPT;
          unique case (req_t'(req_type))
            REQ_FRAME:   state_next = S_F_END;
            REQ_CONSUME: state_next = S_C_START;
            REQ_RESET:   state_next = S_R_APPLY;
            REQ_LIMIT:   state_next = S_L_APPLY;
          endcase
        end
      end
      S_F_END: begin
        op         = OP_F_END;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        op         = OP_F_CHK;
        state_next = stat.frame_scan ? S_F_TRIM : S_EMIT;
      end
      S_F_TRIM: begin
        op         = OP_F_TRIM;
        state_next = S_F_SCAN;
      end
      S_F_SCAN: begin
        if (!stat.pass_busy) state_next = S_F_EVAL1;
      end
      S_F_EVAL1: begin
        op         = OP_F_EVAL1;
        state_next = S_F_EVAL2;
      end
      S_F_EVAL2: begin
        op         = OP_F_EVAL2;
        state_next = stat.frame_fit ? S_F_COMPACT : S_EMIT;
      end
      S_F_COMPACT: begin
        if (!stat.pass_busy) state_next = S_F_APPEND;
      end
      S_F_APPEND: begin
        op         = OP_F_APPEND;
        state_next = S_EMIT;
      end
      S_C_START: begin
        op         = OP_C_START;
        state_next = S_C_FIND;
      end
      S_C_FIND: begin
        if (!stat.pass_busy) state_next = S_C_EVAL;
      end
      S_C_EVAL: begin
        op         = OP_C_EVAL;
        state_next = S_C_APPLY;
      end
      S_C_APPLY: begin
        op = OP_C_APPLY;
        if (!stat.found || stat.n_zero) state_next = S_EMIT;
        else if (stat.emptied)          state_next = S_C_SHIFT;
        else                            state_next = S_C_READY;
      end
      S_C_SHIFT: begin
        if (!stat.pass_busy) state_next = S_C_SHRINK;
      end
      S_C_SHRINK: begin
        op         = OP_C_SHRINK;
        state_next = S_C_READY;
      end
      S_C_READY: begin
        if (!stat.pass_busy) state_next = S_EMIT;
      end
      S_R_APPLY: begin
        op         = OP_R_APPLY;
        state_next = S_EMIT;
      end
      S_L_APPLY: begin
        op         = OP_L_APPLY;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_stall) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/srra_datapath.sv
// Datapath of the reassembly unit: stream state, range table passes and result register.
// Depends on srra_pkg and srra_ram.
module srra_datapath
  import srra_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  op_t                  op,
  output stat_t                stat,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [OFS_W-1:0]     offset,
  input  logic [OFS_W-1:0]     length,
  input  logic                 fin,
  input  logic [OFS_W-1:0]     value,
  input  logic [OFS_W-1:0]     error_code,
  input  logic [LEN_W-1:0]     read_capacity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ST_W-1:0]      status,
  output logic [LEN_W-1:0]     new_bytes,
  output logic [OFS_W-1:0]     read_offset,
  output logic [LEN_W-1:0]     read_length,
  output logic                 finished,
  output logic                 readable,
  output logic                 receive_closed,
  output logic                 reset_seen
);

  localparam int IW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW  = $clog2(MAX_RANGES + 1);
  localparam int GW  = (CW > GAP_W) ? CW : GAP_W;
  localparam int OVW = LEN_W + CW;
  localparam int RW  = OFS_W + LEN_W;

  // configuration
  logic [ID_W-1:0]  id_type;
  logic [LEN_W-1:0] buf_limit;
  logic [GAP_W-1:0] gap_limit;

  // stream state
  logic [CW-1:0]    count;
  logic [OFS_W-1:0] consumed, highest, final_size, recv_limit, peer_err;
  logic [LEN_W-1:0] buffered;
  logic             final_known, peer_reset, data_ready;

  // request and work registers
  logic [OFS_W-1:0]      rq_off, rq_len, rq_val, rq_err;
  logic                  rq_fin;
  logic [LEN_W-1:0]      rq_cap;
  logic [OFS_W:0]        f_end, uend;
  logic [OFS_W-1:0]      len_t, ustart, uniq;
  logic [OVW-1:0]        overlap;
  logic [LEN_W-1:0]      room, n;
  logic [MAX_RANGES-1:0] hit;
  logic [CW-1:0]         w;
  logic                  found;
  logic [IW-1:0]         f_idx;
  logic [OFS_W-1:0]      f_start;
  logic [LEN_W-1:0]      f_len;

  status_t          res_status, out_status;
  logic [LEN_W-1:0] res_fresh, res_rlen;
  logic [OFS_W-1:0] res_roff;
  logic             res_seen;

  // pass engine
  pass_t            pmode, pass_sel;
  logic             pass_go, rd_on, v0, v1, v2;
  logic [CW-1:0]    rd_idx, pass_from, cnt_now;
  logic [IW-1:0]    j0, j1;
  logic [OFS_W-1:0] cs1, os2, oe2;
  logic [OFS_W:0]   ce1;
  logic             hit2;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [OFS_W-1:0] fe, rd_start;
  logic [LEN_W-1:0] rd_len, new_len, ov_part;
  logic             send_only, chk_proto, frame_scan, frame_fit, tbl_full, r_proto;
  logic             fin_now, hit_now;

  assign send_only = id_type[1] & ~id_type[0];
  assign fe        = f_end[OFS_W-1:0];
  assign rd_start  = ram_rdata[RW-1:LEN_W];
  assign rd_len    = ram_rdata[LEN_W-1:0];
  assign new_len   = uend[LEN_W-1:0] - ustart[LEN_W-1:0];
  assign ov_part   = oe2[LEN_W-1:0] - os2[LEN_W-1:0];
  assign fin_now   = final_known && (consumed == final_size);

  assign chk_proto = (fe > recv_limit) || (final_known && (fe > final_size)) ||
                     (rq_fin && final_known && (final_size != fe));
  assign frame_scan = !f_end[OFS_W] && !send_only && !chk_proto && !peer_reset &&
                      (rq_len != '0) && (fe > consumed);
  assign tbl_full  = (GW'(count) >= GW'(gap_limit)) || (count >= CW'(MAX_RANGES));
  assign frame_fit = !(uniq > OFS_W'(room)) && !(!(|hit) && tbl_full);
  assign r_proto   = (final_known && (final_size != rq_val)) || (rq_val < highest) ||
                     (rq_val < consumed) || (rq_val > recv_limit);
  assign hit_now   = !((fe < cs1) || ({1'b0, rq_off} > ce1));

  assign stat.pass_busy  = rd_on | v0 | v1 | v2;
  assign stat.frame_scan = frame_scan;
  assign stat.frame_fit  = frame_fit;
  assign stat.found      = found;
  assign stat.n_zero     = (n == '0);
  assign stat.emptied    = (f_len == n);
  assign stat.out_stall  = out_valid && !out_ready;

  // pass launch
  always_comb begin
    pass_go   = 1'b0;
    pass_sel  = PASS_READY;
    pass_from = '0;
    cnt_now   = count;
    case (op)
      OP_F_TRIM: begin
        pass_go  = 1'b1;
        pass_sel = PASS_MERGE;
      end
      OP_F_EVAL2: begin
        pass_go  = frame_fit;
        pass_sel = PASS_COMPACT;
      end
      OP_C_START: begin
        pass_go  = 1'b1;
        pass_sel = PASS_FIND;
      end
      OP_C_APPLY: begin
        pass_go = found && (n != '0);
        if (f_len == n) begin
          pass_sel  = PASS_SHIFT;
          pass_from = CW'(f_idx) + CW'(1);
        end
      end
      OP_C_SHRINK: begin
        pass_go = 1'b1;
        cnt_now = count - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_on <= 1'b0;
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      if (pass_go) begin
        pmode  <= pass_sel;
        rd_idx <= pass_from;
        rd_on  <= (pass_from < cnt_now);
      end else if (rd_on) begin
        rd_idx <= rd_idx + CW'(1);
        rd_on  <= ((rd_idx + CW'(1)) < count);
      end
      v0 <= rd_on;
      v1 <= v0 && (pmode == PASS_MERGE);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    j0  <= rd_idx[IW-1:0];
    j1  <= j0;
    cs1 <= rd_start;
    ce1 <= {1'b0, rd_start} + (OFS_W + 1)'(rd_len);
    hit2 <= hit_now;
    os2  <= (rq_off > cs1) ? rq_off : cs1;
    oe2  <= ({1'b0, fe} < ce1) ? fe : ce1[OFS_W-1:0];
  end

  // table writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w[IW-1:0];
    ram_wdata = ram_rdata;
    if (v0 && (pmode == PASS_COMPACT) && !hit[j0]) begin
      ram_we = 1'b1;
    end
    if (v0 && (pmode == PASS_SHIFT)) begin
      ram_we    = 1'b1;
      ram_waddr = j0 - IW'(1);
    end
    if (op == OP_F_APPEND) begin
      ram_we    = 1'b1;
      ram_wdata = {ustart, new_len};
    end
    if ((op == OP_C_APPLY) && found && (n != '0) && (f_len != n)) begin
      ram_we    = 1'b1;
      ram_waddr = f_idx;
      ram_wdata = {f_start + OFS_W'(n), f_len - n};
    end
  end

  srra_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_RANGES)
  ) u_ranges (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx[IW-1:0]),
    .rdata(ram_rdata)
  );

  // configuration and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      id_type     <= '0;
      buf_limit   <= BUF_LIMIT_RST;
      gap_limit   <= GAP_LIMIT_RST;
      count       <= '0;
      consumed    <= '0;
      buffered    <= '0;
      highest     <= '0;
      final_size  <= '0;
      final_known <= 1'b0;
      recv_limit  <= OFS_ALL_ONES;
      peer_reset  <= 1'b0;
      peer_err    <= '0;
      data_ready  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ID_TYPE:   id_type   <= cfg_data[ID_W-1:0];
          CFG_BUF_LIMIT: buf_limit <= cfg_data[LEN_W-1:0];
          CFG_GAP_LIMIT: gap_limit <= cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (pass_go && (pass_sel == PASS_READY || pass_sel == PASS_COMPACT)) begin
        data_ready <= 1'b0;
      end
      if (v0 && (pmode == PASS_READY || (pmode == PASS_COMPACT && !hit[j0])) &&
          (rd_start == consumed) && (rd_len != '0)) begin
        data_ready <= 1'b1;
      end
      case (op)
        OP_F_CHK: begin
          if (!f_end[OFS_W] && !send_only && !chk_proto) begin
            if (rq_fin) begin
              final_known <= 1'b1;
              final_size  <= fe;
            end
            if (!peer_reset && (rq_len == '0) && (fe > highest)) highest <= fe;
          end
        end
        OP_F_APPEND: begin
          count    <= w + CW'(1);
          buffered <= buffered + uniq[LEN_W-1:0];
          if (fe > highest) highest <= fe;
          if ((ustart == consumed) && (new_len != '0)) data_ready <= 1'b1;
        end
        OP_C_APPLY: begin
          if (found && (n != '0)) begin
            consumed <= consumed + OFS_W'(n);
            buffered <= (buffered >= n) ? buffered - n : '0;
          end
        end
        OP_C_SHRINK: count <= count - CW'(1);
        OP_R_APPLY: begin
          if (!send_only && !r_proto && !peer_reset) begin
            final_known <= 1'b1;
            final_size  <= rq_val;
            peer_reset  <= 1'b1;
            peer_err    <= rq_err;
            highest     <= rq_val;
          end
        end
        OP_L_APPLY: begin
          if (!(rq_val < highest)) recv_limit <= rq_val;
        end
        default: ;
      endcase
      if (op == OP_EMIT)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // request, work and result registers
  always_ff @(posedge clk) begin
    if (v1 && hit_now) begin
      hit[j1] <= 1'b1;
      if (cs1 < ustart) ustart <= cs1;
      if (ce1 > uend)   uend   <= ce1;
    end
    if (v2 && hit2 && (oe2 > os2)) overlap <= overlap + OVW'(ov_part);
    if (v0 && (pmode == PASS_COMPACT) && !hit[j0]) w <= w + CW'(1);
    if (v0 && (pmode == PASS_FIND) && !found && (rd_start == consumed)) begin
      found   <= 1'b1;
      f_idx   <= j0;
      f_start <= rd_start;
      f_len   <= rd_len;
    end
    case (op)
      OP_ACCEPT: begin
        rq_off     <= offset;
        rq_len     <= length;
        rq_fin     <= fin;
        rq_val     <= value;
        rq_err     <= error_code;
        rq_cap     <= read_capacity;
        res_status <= ST_OK;
        res_fresh  <= '0;
        res_roff   <= (req_t'(req_type) == REQ_CONSUME) ? consumed : '0;
        res_rlen   <= '0;
        res_seen   <= 1'b0;
      end
      OP_F_END: f_end <= {1'b0, rq_off} + {1'b0, rq_len};
      OP_F_CHK: begin
        if (f_end[OFS_W])  res_status <= ST_PARAM;
        else if (send_only) res_status <= ST_STATE;
        else if (chk_proto) res_status <= ST_PROTO;
        else if (peer_reset) begin
          res_status <= (rq_fin || (fe <= final_size)) ? ST_OK : ST_PROTO;
        end
        // trim the frame to the consumed offset
        if (frame_scan && (rq_off < consumed)) rq_off <= consumed;
      end
      OP_F_TRIM: begin
        len_t   <= fe - rq_off;
        ustart  <= rq_off;
        uend    <= {1'b0, fe};
        overlap <= '0;
        hit     <= '0;
      end
      OP_F_EVAL1: begin
        uniq <= len_t - OFS_W'(overlap);
        room <= (buf_limit > buffered) ? buf_limit - buffered : '0;
      end
      OP_F_EVAL2: begin
        if (!frame_fit) res_status <= ST_NORES;
        else            w          <= '0;
      end
      OP_F_APPEND: res_fresh <= uniq[LEN_W-1:0];
      OP_C_START:  found <= 1'b0;
      OP_C_EVAL:   n <= (rq_cap < f_len) ? rq_cap : f_len;
      OP_C_APPLY: begin
        if (!found) begin
          res_status <= (peer_reset && (buffered == '0)) ? ST_RESET : ST_OK;
        end else if (n == '0) begin
          res_status <= ST_SMALL;
        end else begin
          res_rlen <= n;
        end
      end
      OP_R_APPLY: begin
        if (send_only)       res_status <= ST_STATE;
        else if (r_proto)    res_status <= ST_PROTO;
        else if (peer_reset) res_status <= (peer_err == rq_err) ? ST_OK : ST_PROTO;
        else                 res_seen   <= 1'b1;
      end
      OP_L_APPLY: res_status <= (rq_val < highest) ? ST_PARAM : ST_OK;
      OP_EMIT: begin
        out_status     <= res_status;
        new_bytes      <= res_fresh;
        read_offset    <= res_roff;
        read_length    <= res_rlen;
        reset_seen     <= res_seen;
        finished       <= fin_now;
        readable       <= !peer_reset && (fin_now || data_ready);
        receive_closed <= send_only || fin_now || peer_reset;
      end
      default: ;
    endcase
  end

  assign status = out_status;

`ifndef ASSERT_OFF
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (ram_we && rd_on) |-> (ram_waddr != rd_idx[IW-1:0]))
    else $error("range table write hits the address being scanned");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (op == OP_F_APPEND) |=> (count != '0))
    else $error("range count empty after a stored frame");

  a_reset_unreadable: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT && peer_reset) |=> !readable)
    else $error("stream reported readable after peer reset");

  a_finish_known: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT && !final_known) |=> !finished)
    else $error("stream finished without a known final size");
`endif

endmodule

### hdl/stream_receive_reassembly_unit.sv
// Stream receive reassembly unit, top level: sequencer plus datapath with range table.
// Depends on srra_pkg, srra_ctrl, srra_datapath and srra_ram.
// One request is in flight at a time.
// The single read port of the range memory sets the pace: one range per cycle in each pass.
// Reset is synchronous: control, counters and stream state clear at once, no clearing pass.
module stream_receive_reassembly_unit
  import srra_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [OFS_W-1:0]     offset,
  input  logic [OFS_W-1:0]     length,
  input  logic                 fin,
  input  logic [OFS_W-1:0]     value,
  input  logic [OFS_W-1:0]     error_code,
  input  logic [LEN_W-1:0]     read_capacity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ST_W-1:0]      status,
  output logic [LEN_W-1:0]     new_bytes,
  output logic [OFS_W-1:0]     read_offset,
  output logic [LEN_W-1:0]     read_length,
  output logic                 finished,
  output logic                 readable,
  output logic                 receive_closed,
  output logic                 reset_seen
);

  // the sequencer drives at most one datapath operation per cycle, none while it waits on a pass or a stalled output
  op_t   op;
  stat_t stat;

  // accept a request only from idle; a finished result may still wait in the
  // output register, and the sequencer holds in its emit step until it drains
  srra_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .stat    (stat),
    .op      (op)
  );

  // frames: bound checks, merge pass over the table, budget check, compaction
  // pass, append of the merged range.
  // consumes: find pass, update of the front range, shift pass when it empties,
  // then a pass that refreshes the readable flag
  srra_datapath #(
    .MAX_RANGES(MAX_RANGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .offset        (offset),
    .length        (length),
    .fin           (fin),
    .value         (value),
    .error_code    (error_code),
    .read_capacity (read_capacity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .new_bytes     (new_bytes),
    .read_offset   (read_offset),
    .read_length   (read_length),
    .finished      (finished),
    .readable      (readable),
    .receive_closed(receive_closed),
    .reset_seen    (reset_seen)
  );

endmodule
